[rtl/fpr_pkg.sv]
// Shared constants and types for the FIFO page replacement tracker.
`timescale 1ns / 1ps

package fpr_pkg;

  localparam int MAX_FRAMES    = 16;
  localparam int FRAME_W       = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W         = $clog2(MAX_FRAMES + 1);

  localparam int ADDR_W        = 32;
  localparam int PAGE_W        = 32;
  localparam int FAULT_W       = 32;
  localparam int FRAME_OUT_W   = 4;
  localparam int FRAME_COUNT_W = 5;
  localparam int PAGE_BYTES_W  = 21;

  localparam int CFG_INDEX_W   = 1;
  localparam int CFG_DATA_W    = 21;

  localparam int DIV_STEPS     = ADDR_W;
  localparam int STEP_W        = $clog2(DIV_STEPS);

  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_COUNT = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PAGE_BYTES  = 1'b1;

  localparam logic [FRAME_COUNT_W-1:0] FRAME_COUNT_RESET = 5'd16;
  localparam logic [PAGE_BYTES_W-1:0]  PAGE_BYTES_RESET  = 21'd4096;

  // One page number moving between the front and back halves.
  typedef struct packed {
    logic              valid;
    logic [PAGE_W-1:0] page;
  } page_beat_t;

  typedef struct packed {
    logic [PAGE_W-1:0]      page_no;
    logic                   hit;
    logic [FRAME_OUT_W-1:0] frame_index;
    logic [FAULT_W-1:0]     fault_total;
  } result_t;

endpackage

[rtl/fpr_divider.sv]
// Front half: bit-serial restoring divider that turns an address into a page number.
`timescale 1ns / 1ps

module fpr_divider (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [fpr_pkg::ADDR_W-1:0]       address,
  input  logic [fpr_pkg::PAGE_BYTES_W-1:0] page_bytes,
  output fpr_pkg::page_beat_t              out,
  input  logic                             out_ready
);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_DONE} state_t;

  state_t                            state;
  logic [fpr_pkg::STEP_W-1:0]        step;
  logic [fpr_pkg::ADDR_W-1:0]        quot;
  logic [fpr_pkg::PAGE_BYTES_W:0]    rem;
  logic [fpr_pkg::PAGE_BYTES_W-1:0]  divisor;

  logic [fpr_pkg::PAGE_BYTES_W:0]    rem_shift;
  logic [fpr_pkg::PAGE_BYTES_W:0]    rem_diff;
  logic                              rem_ge;

  assign in_ready = (state == S_IDLE) || ((state == S_DONE) && out_ready);

  assign out.valid = (state == S_DONE);
  assign out.page  = quot;

  // Bring in the next dividend bit and try the subtract.
  always_comb begin
    rem_shift = {rem[fpr_pkg::PAGE_BYTES_W-1:0], quot[fpr_pkg::ADDR_W-1]};
    rem_ge    = (rem_shift >= {1'b0, divisor});
    rem_diff  = rem_shift - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            quot    <= address;
            rem     <= '0;
            step    <= '0;
            // A zero page size divides as one.
            divisor <= (page_bytes == '0) ? fpr_pkg::PAGE_BYTES_W'(1) : page_bytes;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          quot <= {quot[fpr_pkg::ADDR_W-2:0], rem_ge};
          rem  <= rem_ge ? rem_diff : rem_shift;
          step <= step + 1'b1;
          if (step == fpr_pkg::STEP_W'(fpr_pkg::DIV_STEPS - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_ready) begin
            if (in_valid) begin
              quot    <= address;
              rem     <= '0;
              step    <= '0;
              divisor <= (page_bytes == '0) ? fpr_pkg::PAGE_BYTES_W'(1) : page_bytes;
              state   <= S_DIV;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/fpr_queue.sv]
// Short queue of page numbers between the divider and the frame table.
`timescale 1ns / 1ps

module fpr_queue (
  input  logic                clk,
  input  logic                rst,
  input  fpr_pkg::page_beat_t in,
  output logic                in_ready,
  output fpr_pkg::page_beat_t out,
  input  logic                out_ready
);

  logic [fpr_pkg::PAGE_W-1:0] mem [fpr_pkg::QUEUE_DEPTH];
  logic [fpr_pkg::QPTR_W-1:0] wr_ptr;
  logic [fpr_pkg::QPTR_W-1:0] rd_ptr;
  logic [fpr_pkg::QCNT_W-1:0] count;
  logic                       do_push;
  logic                       do_pop;

  assign in_ready  = (count != fpr_pkg::QCNT_W'(fpr_pkg::QUEUE_DEPTH));
  assign out.valid = (count != '0);
  assign out.page  = mem[rd_ptr];
  assign do_push   = in.valid && in_ready;
  assign do_pop    = out.valid && out_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= in.page;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == fpr_pkg::QPTR_W'(fpr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == fpr_pkg::QPTR_W'(fpr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/fpr_table.sv]
// Back half: resident page table, FIFO replacement, fault count and result register.
`timescale 1ns / 1ps

module fpr_table (
  input  logic                              clk,
  input  logic                              rst,
  input  fpr_pkg::page_beat_t               in,
  output logic                              in_ready,
  input  logic [fpr_pkg::FRAME_COUNT_W-1:0] frame_count,
  output fpr_pkg::result_t                  result,
  output logic                              out_valid,
  input  logic                              out_ready
);

  logic [fpr_pkg::PAGE_W-1:0]  frame_pages [fpr_pkg::MAX_FRAMES];
  logic [fpr_pkg::MAX_FRAMES-1:0] frame_valid;
  logic [fpr_pkg::FRAME_W-1:0] oldest_pointer;
  logic [fpr_pkg::CNT_W-1:0]   filled_count;
  logic [fpr_pkg::FAULT_W-1:0] fault_counter;

  logic                        take;
  logic [fpr_pkg::CNT_W-1:0]   count;
  logic                        found;
  logic [fpr_pkg::FRAME_W-1:0] hit_frame;
  logic                        table_full;
  logic [fpr_pkg::CNT_W-1:0]   ptr_wide;
  logic [fpr_pkg::CNT_W-1:0]   ptr_base;
  logic [fpr_pkg::CNT_W-1:0]   ptr_inc;
  logic [fpr_pkg::FRAME_W-1:0] oldest_pointer_next;
  logic [fpr_pkg::FRAME_W-1:0] miss_frame;
  logic [fpr_pkg::FAULT_W-1:0] fault_counter_next;

  assign in_ready = !out_valid || out_ready;
  assign take     = in.valid && in_ready;

  // Clamp the configured frame count into 1..MAX_FRAMES.
  always_comb begin
    if (frame_count == '0) begin
      count = fpr_pkg::CNT_W'(1);
    end else if (32'(frame_count) > fpr_pkg::MAX_FRAMES) begin
      count = fpr_pkg::CNT_W'(fpr_pkg::MAX_FRAMES);
    end else begin
      count = fpr_pkg::CNT_W'(frame_count);
    end
  end

  // Parallel tag compare; the lowest matching frame wins.
  always_comb begin
    found     = 1'b0;
    hit_frame = '0;
    for (int i = fpr_pkg::MAX_FRAMES - 1; i >= 0; i--) begin
      if (frame_valid[i] && (frame_pages[i] == in.page) &&
          (fpr_pkg::CNT_W'(i) < count)) begin
        found     = 1'b1;
        hit_frame = fpr_pkg::FRAME_W'(i);
      end
    end
  end

  // Victim choice: next free frame, or the oldest once the table is full.
  always_comb begin
    table_full          = (filled_count >= count);
    ptr_wide            = fpr_pkg::CNT_W'(oldest_pointer);
    ptr_base            = (ptr_wide >= count) ? '0 : ptr_wide;
    ptr_inc             = ptr_base + 1'b1;
    oldest_pointer_next = (ptr_inc >= count) ? '0 : fpr_pkg::FRAME_W'(ptr_inc);
    miss_frame          = table_full ? fpr_pkg::FRAME_W'(ptr_base)
                                     : fpr_pkg::FRAME_W'(filled_count);
    fault_counter_next  = (fault_counter == '1) ? fault_counter : fault_counter + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (take && !found) begin
      frame_pages[miss_frame] <= in.page;
    end
    if (take) begin
      result.page_no     <= in.page;
      result.hit         <= found;
      result.frame_index <= fpr_pkg::FRAME_OUT_W'(found ? hit_frame : miss_frame);
      result.fault_total <= found ? fault_counter : fault_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid    <= '0;
      oldest_pointer <= '0;
      filled_count   <= '0;
      fault_counter  <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (take) begin
        out_valid <= 1'b1;
        if (!found) begin
          frame_valid[miss_frame] <= 1'b1;
          fault_counter           <= fault_counter_next;
          if (table_full) begin
            oldest_pointer <= oldest_pointer_next;
          end else begin
            filled_count <= filled_count + 1'b1;
          end
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/fifo_page_replacement_tracker.sv]
// Top level of the FIFO page replacement tracker: config registers and the three stages.
`timescale 1ns / 1ps
//
// Usage:
//   Push one address per beat on address/push; full high means hold the beat.
//   Results come out in order on page_no, hit, frame_index and fault_total
//   while empty is low; pop takes the oldest one.
//   Configuration: cfg_write with cfg_index 0 sets frame_count (low 5 bits of
//   cfg_data), index 1 sets page_bytes. Write only while no address is in flight.
// Timing:
//   The divider produces one quotient bit per cycle and takes a new address only
//   as it hands its quotient to the queue, so that divider sets the sustained rate.
//   A result passes from the divider through the queue into the result register
//   before it appears on the ports.
// Reset (rst, synchronous): all frames invalid, fault count, fill count and
//   the oldest pointer cleared, frame_count = 16 and page_bytes = 4096.
// Stalls: when pop stays low the result register holds, the two-entry queue
//   fills, then the divider holds its quotient and full stays high.
//
module fifo_page_replacement_tracker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic [fpr_pkg::ADDR_W-1:0]          address,
  output logic                                empty,
  input  logic                                pop,
  output logic [fpr_pkg::PAGE_W-1:0]          page_no,
  output logic                                hit,
  output logic [fpr_pkg::FRAME_OUT_W-1:0]     frame_index,
  output logic [fpr_pkg::FAULT_W-1:0]         fault_total,
  input  logic                                cfg_write,
  input  logic [fpr_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [fpr_pkg::CFG_DATA_W-1:0]      cfg_data
);

  logic [fpr_pkg::FRAME_COUNT_W-1:0] frame_count;
  logic [fpr_pkg::PAGE_BYTES_W-1:0]  page_bytes;

  logic                 div_in_ready;
  fpr_pkg::page_beat_t  div_beat;
  logic                 mq_in_ready;
  fpr_pkg::page_beat_t  mq_beat;
  logic                 tbl_in_ready;
  fpr_pkg::result_t     tbl_result;
  logic                 tbl_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= fpr_pkg::FRAME_COUNT_RESET;
      page_bytes  <= fpr_pkg::PAGE_BYTES_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        fpr_pkg::CFG_FRAME_COUNT: frame_count <= cfg_data[fpr_pkg::FRAME_COUNT_W-1:0];
        fpr_pkg::CFG_PAGE_BYTES:  page_bytes  <= cfg_data[fpr_pkg::PAGE_BYTES_W-1:0];
        default: begin
        end
      endcase
    end
  end

  fpr_divider u_divider (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (push),
    .in_ready   (div_in_ready),
    .address    (address),
    .page_bytes (page_bytes),
    .out        (div_beat),
    .out_ready  (mq_in_ready)
  );

  fpr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in        (div_beat),
    .in_ready  (mq_in_ready),
    .out       (mq_beat),
    .out_ready (tbl_in_ready)
  );

  fpr_table u_table (
    .clk         (clk),
    .rst         (rst),
    .in          (mq_beat),
    .in_ready    (tbl_in_ready),
    .frame_count (frame_count),
    .result      (tbl_result),
    .out_valid   (tbl_valid),
    .out_ready   (pop)
  );

  assign full        = !div_in_ready;
  assign empty       = !tbl_valid;
  assign page_no     = tbl_result.page_no;
  assign hit         = tbl_result.hit;
  assign frame_index = tbl_result.frame_index;
  assign fault_total = tbl_result.fault_total;

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result present right after reset");

  // An accepted address keeps the divider busy on the next cycle.
  a_div_busy: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> full)
    else $error("divider accepted a second address too early");

  // A finished quotient waits in the divider while the queue is full.
  a_div_hold: assert property (@(posedge clk) disable iff (rst)
    (div_beat.valid && !mq_in_ready) |=> (div_beat.valid && $stable(div_beat.page)))
    else $error("quotient lost while queue full");

endmodule
